@@ design/qvr_pkg.sv @@
// Package for the quaternion vector rotation block: widths and limits.
`default_nettype none
package qvr_pkg;
    localparam int COMPONENT_WIDTH = 16;
    localparam int QW       = 16;   // working quaternion component width
    localparam int VEC_W    = 16;
    localparam int OUT_W    = 17;
    localparam int SQ_W     = 32;   // 16x16 product
    localparam int MAT_W    = 34;   // matrix entry and norm
    localparam int PROD_W   = 50;   // matrix entry times vector coordinate
    localparam int REM_W    = 52;   // numerator and remainder
    localparam int QBITS    = 17;   // quotient bits
    localparam int NSTAGE   = 17;   // one quotient bit per stage

    localparam logic [QBITS-1:0] POS_LIMIT = 17'd65535;
    localparam logic [QBITS-1:0] NEG_LIMIT = 17'd65536;
endpackage
`default_nettype wire

@@ design/quaternion_vector_rotate_top.sv @@
// Pipelined quaternion vector rotation with rounded division by the norm.
// Usage:
//   Input channel in_valid/in_ready carries quat_w..quat_z and vec_x..vec_z.
//   Output channel out_valid/out_ready carries rot_x..rot_z and zero_norm.
//   A transfer happens on each edge where valid and ready are both high.
// Throughput: one item per cycle unless the output stalls. Path: the input
//   transfer passes five arithmetic stages (products, matrix entries, matrix
//   times vector, sums, rounding setup), seventeen restoring-division stages
//   (one quotient bit each) and the output register before out_valid rises.
// The result equals R(q)*v / |q|^2 rounded half away from zero and clamped
//   to 17 bits; an all-zero quaternion gives zero with zero_norm set.
// Wide components are cut to their 16 most significant bits first.
// Stall: when out_valid is high and out_ready low the whole pipeline holds
//   and in_ready drops; nothing is lost or repeated.
// Reset: rst_n clears all valid bits asynchronously; the pipeline is empty
//   and ready right after reset.
`default_nettype none
module quaternion_vector_rotate_top #(
    parameter int COMPONENT_WIDTH = qvr_pkg::COMPONENT_WIDTH
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    output logic                                        in_ready,
    input  wire logic signed [COMPONENT_WIDTH-1:0]      quat_w,
    input  wire logic signed [COMPONENT_WIDTH-1:0]      quat_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0]      quat_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0]      quat_z,
    input  wire logic signed [qvr_pkg::VEC_W-1:0]       vec_x,
    input  wire logic signed [qvr_pkg::VEC_W-1:0]       vec_y,
    input  wire logic signed [qvr_pkg::VEC_W-1:0]       vec_z,
    output logic                                        out_valid,
    input  wire logic                                   out_ready,
    output logic signed [qvr_pkg::OUT_W-1:0]            rot_x,
    output logic signed [qvr_pkg::OUT_W-1:0]            rot_y,
    output logic signed [qvr_pkg::OUT_W-1:0]            rot_z,
    output logic                                        zero_norm
);
    localparam int QW     = qvr_pkg::QW;
    localparam int VW     = qvr_pkg::VEC_W;
    localparam int SQ_W   = qvr_pkg::SQ_W;
    localparam int MAT_W  = qvr_pkg::MAT_W;
    localparam int PROD_W = qvr_pkg::PROD_W;
    localparam int REM_W  = qvr_pkg::REM_W;
    localparam int QBITS  = qvr_pkg::QBITS;
    localparam int NSTAGE = qvr_pkg::NSTAGE;
    localparam int OUT_W  = qvr_pkg::OUT_W;

    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // component cut
    logic signed [QW-1:0] qw, qx, qy, qz;
    generate
        if (COMPONENT_WIDTH > QW) begin : g_cut
            assign qw = quat_w[COMPONENT_WIDTH-1 -: QW];
            assign qx = quat_x[COMPONENT_WIDTH-1 -: QW];
            assign qy = quat_y[COMPONENT_WIDTH-1 -: QW];
            assign qz = quat_z[COMPONENT_WIDTH-1 -: QW];
        end
        else begin : g_ext
            assign qw = QW'(quat_w);
            assign qx = QW'(quat_x);
            assign qy = QW'(quat_y);
            assign qz = QW'(quat_z);
        end
    endgenerate

    // stage 1: component products
    logic                   v1_reg;
    logic signed [SQ_W-1:0] ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [SQ_W-1:0] xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [VW-1:0]   vx1_reg, vy1_reg, vz1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg  <= qw * qw;
            xx_reg  <= qx * qx;
            yy_reg  <= qy * qy;
            zz_reg  <= qz * qz;
            xy_reg  <= qx * qy;
            xz_reg  <= qx * qz;
            yz_reg  <= qy * qz;
            wx_reg  <= qw * qx;
            wy_reg  <= qw * qy;
            wz_reg  <= qw * qz;
            vx1_reg <= vec_x;
            vy1_reg <= vec_y;
            vz1_reg <= vec_z;
        end
    end

    // stage 2: unnormalized rotation matrix and squared norm
    logic                    v2_reg;
    logic signed [MAT_W-1:0] m_reg [0:8];
    logic signed [MAT_W-1:0] n2_reg;
    logic signed [VW-1:0]    vx2_reg, vy2_reg, vz2_reg;
    logic signed [MAT_W-1:0] ew, ex, ey, ez, exy, exz, eyz, ewx, ewy, ewz;

    always_comb
    begin
        ew  = MAT_W'(ww_reg);
        ex  = MAT_W'(xx_reg);
        ey  = MAT_W'(yy_reg);
        ez  = MAT_W'(zz_reg);
        exy = MAT_W'(xy_reg);
        exz = MAT_W'(xz_reg);
        eyz = MAT_W'(yz_reg);
        ewx = MAT_W'(wx_reg);
        ewy = MAT_W'(wy_reg);
        ewz = MAT_W'(wz_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= ew + ex - ey - ez;
            m_reg[1] <= (exy - ewz) <<< 1;
            m_reg[2] <= (exz + ewy) <<< 1;
            m_reg[3] <= (exy + ewz) <<< 1;
            m_reg[4] <= ew - ex + ey - ez;
            m_reg[5] <= (eyz - ewx) <<< 1;
            m_reg[6] <= (exz - ewy) <<< 1;
            m_reg[7] <= (eyz + ewx) <<< 1;
            m_reg[8] <= ew - ex - ey + ez;
            n2_reg   <= ew + ex + ey + ez;
            vx2_reg  <= vx1_reg;
            vy2_reg  <= vy1_reg;
            vz2_reg  <= vz1_reg;
        end
    end

    // stage 3: matrix times vector, nine products
    logic                     v3_reg;
    logic signed [PROD_W-1:0] p_reg [0:8];
    logic signed [MAT_W-1:0]  n23_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                p_reg[3*r]   <= m_reg[3*r]   * vx2_reg;
                p_reg[3*r+1] <= m_reg[3*r+1] * vy2_reg;
                p_reg[3*r+2] <= m_reg[3*r+2] * vz2_reg;
            end
            n23_reg <= n2_reg;
        end
    end

    // stage 4: row sums
    logic                    v4_reg;
    logic signed [REM_W-1:0] s_reg [0:2];
    logic signed [MAT_W-1:0] n24_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                s_reg[r] <= REM_W'(p_reg[3*r]) + REM_W'(p_reg[3*r+1])
                          + REM_W'(p_reg[3*r+2]);
            end
            n24_reg <= n23_reg;
        end
    end

    // stage 5: rounding setup, N = 2|s| + n2 over D = 2*n2
    logic             dvalid_reg [0:NSTAGE];
    logic [REM_W-1:0] rem_reg    [0:NSTAGE][0:2];
    logic [QBITS-1:0] quo_reg    [0:NSTAGE][0:2];
    logic             neg_reg    [0:NSTAGE][0:2];
    logic             ovf_reg    [0:NSTAGE][0:2];
    logic [MAT_W-1:0] den_reg    [0:NSTAGE];
    logic             zero_reg   [0:NSTAGE];

    logic [MAT_W-1:0] den5;
    logic [REM_W-1:0] mag5 [0:2];
    logic [REM_W-1:0] num5 [0:2];
    logic [REM_W-1:0] top5;

    always_comb
    begin
        den5 = MAT_W'(n24_reg) << 1;
        top5 = REM_W'(den5) << QBITS;
        for (int r = 0; r < 3; r++)
        begin
            mag5[r] = s_reg[r][REM_W-1] ? REM_W'(-s_reg[r]) : REM_W'(s_reg[r]);
            num5[r] = (mag5[r] << 1) + REM_W'(MAT_W'(n24_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvalid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dvalid_reg[0] <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                rem_reg[0][r] <= num5[r];
                quo_reg[0][r] <= '0;
                neg_reg[0][r] <= s_reg[r][REM_W-1];
                ovf_reg[0][r] <= num5[r] >= top5;
            end
            den_reg[0]  <= den5;
            zero_reg[0] <= (n24_reg == '0);
        end
    end

    // restoring division, one quotient bit per stage, MSB first
    genvar j;
    generate
        for (j = 0; j < NSTAGE; j++) begin : g_div
            localparam int BIT = NSTAGE - 1 - j;
            logic [REM_W-1:0] dsh;
            logic [REM_W-1:0] rem_next [0:2];
            logic             take     [0:2];

            always_comb
            begin
                dsh = REM_W'(den_reg[j]) << BIT;
                for (int r = 0; r < 3; r++)
                begin
                    take[r]     = rem_reg[j][r] >= dsh;
                    rem_next[r] = take[r] ? rem_reg[j][r] - dsh : rem_reg[j][r];
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dvalid_reg[j+1] <= 1'b0;
                end
                else if (en)
                begin
                    dvalid_reg[j+1] <= dvalid_reg[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    for (int r = 0; r < 3; r++)
                    begin
                        rem_reg[j+1][r] <= rem_next[r];
                        quo_reg[j+1][r] <= quo_reg[j][r] | (QBITS'(take[r]) << BIT);
                        neg_reg[j+1][r] <= neg_reg[j][r];
                        ovf_reg[j+1][r] <= ovf_reg[j][r];
                    end
                    den_reg[j+1]  <= den_reg[j];
                    zero_reg[j+1] <= zero_reg[j];
                end
            end
        end
    endgenerate

    // output stage: sign, clamp, zero quaternion
    logic             out_valid_reg;
    logic [OUT_W-1:0] rot_reg [0:2];
    logic             zero_norm_reg;
    logic [OUT_W-1:0] rot_next [0:2];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            if (zero_reg[NSTAGE])
            begin
                rot_next[r] = '0;
            end
            else if (neg_reg[NSTAGE][r])
            begin
                if (ovf_reg[NSTAGE][r] || quo_reg[NSTAGE][r] > qvr_pkg::NEG_LIMIT)
                    rot_next[r] = OUT_W'(-qvr_pkg::NEG_LIMIT);
                else
                    rot_next[r] = OUT_W'(-quo_reg[NSTAGE][r]);
            end
            else
            begin
                if (ovf_reg[NSTAGE][r] || quo_reg[NSTAGE][r] > qvr_pkg::POS_LIMIT)
                    rot_next[r] = OUT_W'(qvr_pkg::POS_LIMIT);
                else
                    rot_next[r] = OUT_W'(quo_reg[NSTAGE][r]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dvalid_reg[NSTAGE];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int r = 0; r < 3; r++)
            begin
                rot_reg[r] <= rot_next[r];
            end
            zero_norm_reg <= zero_reg[NSTAGE];
        end
    end

    assign out_valid = out_valid_reg;
    assign rot_x     = rot_reg[0];
    assign rot_y     = rot_reg[1];
    assign rot_z     = rot_reg[2];
    assign zero_norm = zero_norm_reg;
endmodule
`default_nettype wire

@@ verif/quaternion_vector_rotate_top_tb.sv @@
// Self-checking testbench for the quaternion vector rotation block.
`default_nettype none
module quaternion_vector_rotate_top_tb;
    localparam int CW = qvr_pkg::COMPONENT_WIDTH;
    localparam int OUT_W = qvr_pkg::OUT_W;
    localparam int VEC_W = qvr_pkg::VEC_W;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic signed [OUT_W-1:0] z;
        logic                    zflag;
    } rot_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [CW-1:0] quat_w, quat_x, quat_y, quat_z;
    logic signed [VEC_W-1:0] vec_x, vec_y, vec_z;
    logic out_valid;
    logic out_ready;
    logic signed [OUT_W-1:0] rot_x, rot_y, rot_z;
    logic zero_norm;

    rot_t expected_rot_q[$];
    int mismatches;
    int results_seen;
    int items_sent;
    int idle_cycles;
    bit random_idle;
    bit hold_output;
    bit stim_done;

    quaternion_vector_rotate_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .rot_x(rot_x), .rot_y(rot_y), .rot_z(rot_z), .zero_norm(zero_norm)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Cut a component to 16 significant bits when the port is wider.
    function automatic longint comp16(logic signed [CW-1:0] c);
        if (CW > 16)
        begin
            return longint'(c >>> (CW - 16));
        end
        return longint'(c);
    endfunction

    function automatic logic signed [OUT_W-1:0] div_round_clamp(longint num, longint den);
        longint mag;
        longint quo;
        mag = (num < 0) ? -num : num;
        quo = (2 * mag + den) / (2 * den);
        if (num < 0)
        begin
            if (quo > 65536)
            begin
                quo = 65536;
            end
            return OUT_W'(-quo);
        end
        if (quo > 65535)
        begin
            quo = 65535;
        end
        return OUT_W'(quo);
    endfunction

    function automatic rot_t rotate_vector(logic signed [CW-1:0] qw, logic signed [CW-1:0] qx,
                                          logic signed [CW-1:0] qy, logic signed [CW-1:0] qz,
                                          logic signed [VEC_W-1:0] px,
                                          logic signed [VEC_W-1:0] py,
                                          logic signed [VEC_W-1:0] pz);
        longint w, x, y, z, vx, vy, vz, n2, nx, ny, nz;
        rot_t r;
        w = comp16(qw);
        x = comp16(qx);
        y = comp16(qy);
        z = comp16(qz);
        vx = px;
        vy = py;
        vz = pz;
        n2 = w*w + x*x + y*y + z*z;
        r = '0;
        if (n2 == 0)
        begin
            r.zflag = 1'b1;
            return r;
        end
        nx = (w*w + x*x - y*y - z*z) * vx + 2 * (x*y - w*z) * vy + 2 * (x*z + w*y) * vz;
        ny = 2 * (x*y + w*z) * vx + (w*w - x*x + y*y - z*z) * vy + 2 * (y*z - w*x) * vz;
        nz = 2 * (x*z - w*y) * vx + 2 * (y*z + w*x) * vy + (w*w - x*x - y*y + z*z) * vz;
        r.x = div_round_clamp(nx, n2);
        r.y = div_round_clamp(ny, n2);
        r.z = div_round_clamp(nz, n2);
        return r;
    endfunction

    // Holds valid and payload until the transfer happens.
    task automatic send_rotation(logic signed [CW-1:0] qw, logic signed [CW-1:0] qx,
                                 logic signed [CW-1:0] qy, logic signed [CW-1:0] qz,
                                 logic signed [VEC_W-1:0] px, logic signed [VEC_W-1:0] py,
                                 logic signed [VEC_W-1:0] pz);
        while (random_idle && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        quat_w <= qw;
        quat_x <= qx;
        quat_y <= qy;
        quat_z <= qz;
        vec_x <= px;
        vec_y <= py;
        vec_z <= pz;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        expected_rot_q.push_back(rotate_vector(qw, qx, qy, qz, px, py, pz));
        items_sent++;
    endtask

    task automatic release_input();
        in_valid <= 1'b0;
    endtask

    function automatic logic signed [CW-1:0] rand_comp();
        return CW'($urandom);
    endfunction

    function automatic logic signed [VEC_W-1:0] rand_coord();
        return VEC_W'($urandom);
    endfunction

    task automatic test_directed();
        logic signed [CW-1:0] one;
        logic signed [CW-1:0] cmax;
        logic signed [CW-1:0] cmin;
        one = CW'(1) <<< (CW - 2);
        cmax = {1'b0, {(CW-1){1'b1}}};
        cmin = {1'b1, {(CW-1){1'b0}}};
        // zero quaternion, with and without a vector
        send_rotation('0, '0, '0, '0, 16'sd0, 16'sd0, 16'sd0);
        send_rotation('0, '0, '0, '0, 16'sd32767, -16'sd32768, 16'sd1234);
        // identity and half turns about each axis
        send_rotation(one, '0, '0, '0, 16'sd32767, -16'sd32768, -16'sd1);
        send_rotation('0, one, '0, '0, 16'sd32767, -16'sd32768, 16'sd5);
        send_rotation('0, '0, one, '0, -16'sd32768, 16'sd32767, -16'sd32768);
        send_rotation('0, '0, '0, one, -16'sd32768, -16'sd32768, 16'sd32767);
        send_rotation(cmin, '0, '0, '0, -16'sd32768, -16'sd32768, -16'sd32768);
        send_rotation(cmax, cmax, cmax, cmax, 16'sd32767, 16'sd32767, 16'sd32767);
        send_rotation(cmin, cmin, cmin, cmin, -16'sd32768, -16'sd32768, -16'sd32768);
        send_rotation(cmax, cmin, cmax, cmin, 16'sd32767, -16'sd32768, 16'sd32767);
        // smallest nonzero norms: coarse quotients and rounding ties
        send_rotation(CW'(1), CW'(1), '0, '0, 16'sd1, 16'sd1, 16'sd1);
        send_rotation(CW'(1), CW'(1), CW'(1), '0, 16'sd3, -16'sd3, 16'sd1);
        send_rotation('0, '0, '0, CW'(-1), 16'sd7, -16'sd7, 16'sd7);
        send_rotation(CW'(1), CW'(-1), CW'(1), CW'(-1), -16'sd32768, 16'sd32767, 16'sd1);
        // quarter turns near the range edges
        send_rotation(CW'(11585), CW'(11585), '0, '0, 16'sd32767, 16'sd32767, -16'sd32768);
        send_rotation(CW'(11585), '0, CW'(-11585), '0, -16'sd32768, 16'sd32767, 16'sd32767);
        send_rotation(CW'(-1), '0, '0, CW'(1), -16'sd32768, -16'sd32768, 16'sd0);
        release_input();
    endtask

    task automatic test_random(int count);
        int kind;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(9);
            if (kind == 0)
            begin
                // tiny components stress rounding
                send_rotation(CW'($urandom_range(6) - 3), CW'($urandom_range(6) - 3),
                              CW'($urandom_range(6) - 3), CW'($urandom_range(6) - 3),
                              rand_coord(), rand_coord(), rand_coord());
            end
            else if (kind == 1)
            begin
                send_rotation(rand_comp(), '0, '0, rand_comp(),
                              rand_coord(), rand_coord(), rand_coord());
            end
            else
            begin
                send_rotation(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                              rand_coord(), rand_coord(), rand_coord());
            end
        end
        release_input();
    endtask

    // Output stalls long enough to fill the pipeline while input keeps coming.
    task automatic test_backpressure();
        fork
            begin
                hold_output = 1'b1;
                repeat (200) @(posedge clk);
                hold_output = 1'b0;
            end
            test_random(80);
        join
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || hold_output)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !(random_idle && $urandom_range(99) < 17);
        end
    end

    always @(posedge clk)
    begin
        rot_t exp_r;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_rot_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result x=%0d y=%0d z=%0d zn=%0b",
                             rot_x, rot_y, rot_z, zero_norm);
                end
            end
            else
            begin
                exp_r = expected_rot_q.pop_front();
                if (rot_x !== exp_r.x || rot_y !== exp_r.y || rot_z !== exp_r.z
                    || zero_norm !== exp_r.zflag)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp %0d %0d %0d zn=%0b got %0d %0d %0d zn=%0b",
                                 exp_r.x, exp_r.y, exp_r.z, exp_r.zflag,
                                 rot_x, rot_y, rot_z, zero_norm);
                    end
                end
            end
        end
    end

    // Watchdog: cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || stim_done)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout: %0d results pending", expected_rot_q.size());
            $display("quaternion_vector_rotate_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        int wait_cycles;
        rst_n = 1'b0;
        in_valid = 1'b0;
        quat_w = '0;
        quat_x = '0;
        quat_y = '0;
        quat_z = '0;
        vec_x = '0;
        vec_y = '0;
        vec_z = '0;
        items_sent = 0;
        random_idle = 1'b0;
        hold_output = 1'b0;
        stim_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(300);        // no idling on either side
        random_idle = 1'b1;
        test_backpressure();
        test_random(1550);

        wait_cycles = 0;
        while (expected_rot_q.size() != 0 && wait_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        stim_done = 1'b1;
        repeat (40) @(posedge clk);

        $display("covered %0d rotations (%0d checked): zero and tiny norms, range edges,",
                 items_sent, results_seen);
        $display("random quaternions under random idling and a long output stall");
        if (mismatches == 0 && expected_rot_q.size() == 0)
        begin
            $display("quaternion_vector_rotate_top regression: pass");
        end
        else
        begin
            $display("%0d mismatches, %0d results missing", mismatches, expected_rot_q.size());
            $display("quaternion_vector_rotate_top regression: fail");
        end
        $finish;
    end
endmodule
`default_nettype wire
